// ----- rtl/tll_pkg.sv -----
package tll_pkg;

   localparam int LINE_BITS = 16;
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam int KEEP = 6;
   localparam logic [2:0] LEN_SAT = 3'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] EV_CHAR  = 2'd0;
   localparam logic [1:0] EV_TOKEN = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;

   localparam logic [1:0] TK_NUMBER = 2'd0;
   localparam logic [1:0] TK_IDENT  = 2'd1;
   localparam logic [1:0] TK_RESVD  = 2'd2;
   localparam logic [1:0] TK_OPER   = 2'd3;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef logic [0:KEEP-1][7:0] prefix_type;

   localparam logic [0:7][0:5][7:0] KW_TEXT = {
      {"read", 16'h0}, {"if", 32'h0}, {"then", 16'h0}, {"else", 16'h0},
      {"write", 8'h0}, "repeat", {"until", 8'h0}, {"end", 24'h0}
   };
   localparam logic [0:7][2:0] KW_LEN = {
      3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd3
   };

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  char_value;
      logic [1:0]  token_kind;
      logic [2:0]  keyword_index;
      logic [15:0] line_number;
      logic        error_seen;
      logic        last_of_run;
   } res_type;

   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } entry_type;

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic is_op(logic [7:0] c);
      return c inside {"+", "-", "*", "/", "<", "=", "(", ")", ";"};
   endfunction

   // {hit, index}
   function automatic logic [3:0] kw_lookup(prefix_type p, logic [2:0] len);
      logic       found;
      logic       match;
      logic [2:0] idx;
      found = 1'b0;
      idx = '0;
      for (int k = 0; k < 8; k++) begin
         match = (len == KW_LEN[k]);
         for (int j = 0; j < 6; j++) begin
            if (3'(j) < KW_LEN[k] && p[j] != KW_TEXT[k][j]) begin
               match = 1'b0;
            end
         end
         if (match && !found) begin
            found = 1'b1;
            idx = 3'(k);
         end
      end
      return {found, idx};
   endfunction

   function automatic res_type mk_res(logic [1:0] ev, logic [7:0] ch, logic [1:0] tk,
                                      logic [2:0] kw, logic [LINE_BITS-1:0] line,
                                      logic err);
      res_type r;
      r.event_kind = ev;
      r.char_value = ch;
      r.token_kind = tk;
      r.keyword_index = kw;
      r.line_number = 16'(line);
      r.error_seen = err;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/tiny_language_lexer_core.sv -----
// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    char_code, end_of_input
// rsp_      out        rsp_valid/rsp_ready    event_kind .. last_of_run
//
// A byte is classified and its results formed in the cycle it is accepted; the
// results enter a four-entry queue and leave one per cycle from the output
// register while rsp_ready is high, so a byte's two results go out one by one.
// A result is held in a queue entry and then in the output register before rsp_.
// Synchronous active-high reset; no clearing pass, requests accepted right after.
// req_ready drops only while the queue is full; rsp_ready stalls back up there.
module tiny_language_lexer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_char_value,
   output logic [1:0]  rsp_token_kind,
   output logic [2:0]  rsp_keyword_index,
   output logic [15:0] rsp_line_number,
   output logic        rsp_error_seen,
   output logic        rsp_last_of_run
);

   logic                req_fire;
   logic                push;
   tll_pkg::entry_type  push_entry;
   logic                q_not_full;
   logic                q_not_empty;
   logic                q_pop;
   tll_pkg::entry_type  q_head;
   tll_pkg::res_type    out_res;

   assign req_ready = q_not_full;
   assign req_fire = req_valid && req_ready;

   tll_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .push         (push),
      .entry        (push_entry)
   );

   tll_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   tll_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_res     (out_res)
   );

   assign rsp_event_kind = out_res.event_kind;
   assign rsp_char_value = out_res.char_value;
   assign rsp_token_kind = out_res.token_kind;
   assign rsp_keyword_index = out_res.keyword_index;
   assign rsp_line_number = out_res.line_number;
   assign rsp_error_seen = out_res.error_seen;
   assign rsp_last_of_run = out_res.last_of_run;

endmodule

// ----- rtl/tll_front.sv -----
module tll_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic [7:0]            char_code,
   input  logic                  end_of_input,
   output logic                  push,
   output tll_pkg::entry_type    entry
);

   localparam logic [2:0] ST_START   = 3'd0;
   localparam logic [2:0] ST_NUM     = 3'd1;
   localparam logic [2:0] ST_ID      = 3'd2;
   localparam logic [2:0] ST_ASSIGN  = 3'd3;
   localparam logic [2:0] ST_COMMENT = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [2:0]                     len_ff, len_in;
   tll_pkg::prefix_type            prefix_ff, prefix_in;
   logic                           err_ff, err_in;
   logic [tll_pkg::LINE_BITS-1:0]  line_ff, line_in;

   tll_pkg::res_type               res [0:1];
   logic [1:0]                     n;
   logic                           do_app;
   logic                           do_sep;
   logic [2:0]                     app_base;
   logic [3:0]                     kw;
   logic [7:0]                     c;

   assign c = char_code;

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      prefix_in = prefix_ff;
      err_in = err_ff;
      line_in = line_ff;
      kw = tll_pkg::kw_lookup(prefix_ff, len_ff);
      n = '0;
      res[0] = '0;
      res[1] = '0;
      do_app = 1'b0;
      do_sep = 1'b0;
      app_base = len_ff;
      if (end_of_input) begin
         state_in = ST_START;
         len_in = '0;
      end else begin
         case (state_ff)
            ST_NUM: begin
               if (tll_pkg::is_digit(c)) begin
                  do_app = 1'b1;
               end else begin
                  res[0] = tll_pkg::mk_res(tll_pkg::EV_TOKEN, 8'h0, tll_pkg::TK_NUMBER,
                                           3'd0, line_ff, err_ff);
                  n = 2'd1;
                  len_in = '0;
                  do_sep = 1'b1;
               end
            end
            ST_ID: begin
               if (tll_pkg::is_letter(c)) begin
                  do_app = 1'b1;
               end else begin
                  if (kw[3]) begin
                     res[0] = tll_pkg::mk_res(tll_pkg::EV_TOKEN, 8'h0, tll_pkg::TK_RESVD,
                                              kw[2:0], line_ff, err_ff);
                  end else begin
                     res[0] = tll_pkg::mk_res(tll_pkg::EV_TOKEN, 8'h0, tll_pkg::TK_IDENT,
                                              3'd0, line_ff, err_ff);
                  end
                  n = 2'd1;
                  len_in = '0;
                  do_sep = 1'b1;
               end
            end
            ST_ASSIGN: begin
               state_in = ST_START;
               len_in = '0;
               if (c == tll_pkg::CH_EQUAL) begin
                  res[0] = tll_pkg::mk_res(tll_pkg::EV_CHAR, c, tll_pkg::TK_NUMBER,
                                           3'd0, line_ff, err_ff);
                  res[1] = tll_pkg::mk_res(tll_pkg::EV_TOKEN, c, tll_pkg::TK_OPER,
                                           3'd0, line_ff, err_ff);
                  n = 2'd2;
               end else begin
                  err_in = 1'b1;
                  res[0] = tll_pkg::mk_res(tll_pkg::EV_ERROR, c, tll_pkg::TK_NUMBER,
                                           3'd0, line_ff, 1'b1);
                  n = 2'd1;
               end
            end
            ST_COMMENT: begin
               if (c == tll_pkg::CH_RBRACE) begin
                  state_in = ST_START;
               end
            end
            default: begin
               state_in = ST_START;
               len_in = '0;
               app_base = '0;
               if (tll_pkg::is_space(c)) begin
                  state_in = ST_START;
               end else if (c == tll_pkg::CH_LBRACE) begin
                  state_in = ST_COMMENT;
               end else if (tll_pkg::is_digit(c)) begin
                  state_in = ST_NUM;
                  do_app = 1'b1;
               end else if (tll_pkg::is_letter(c)) begin
                  state_in = ST_ID;
                  do_app = 1'b1;
               end else if (c == tll_pkg::CH_COLON) begin
                  state_in = ST_ASSIGN;
                  do_app = 1'b1;
               end else begin
                  do_sep = 1'b1;
               end
            end
         endcase

         if (do_app) begin
            if (app_base < 3'(tll_pkg::KEEP)) begin
               prefix_in[app_base] = c;
            end
            len_in = (app_base < tll_pkg::LEN_SAT) ? app_base + 3'd1 : app_base;
            res[n[0]] = tll_pkg::mk_res(tll_pkg::EV_CHAR, c, tll_pkg::TK_NUMBER, 3'd0,
                                        line_ff, err_in);
            n = n + 2'd1;
         end

         if (do_sep) begin
            state_in = ST_START;
            if (tll_pkg::is_op(c)) begin
               res[n[0]] = tll_pkg::mk_res(tll_pkg::EV_TOKEN, c, tll_pkg::TK_OPER, 3'd0,
                                           line_ff, err_in);
               n = n + 2'd1;
            end else if (!tll_pkg::is_space(c)) begin
               err_in = 1'b1;
               res[n[0]] = tll_pkg::mk_res(tll_pkg::EV_ERROR, c, tll_pkg::TK_NUMBER, 3'd0,
                                           line_ff, 1'b1);
               n = n + 2'd1;
            end
         end

         if (c == tll_pkg::CH_LF && line_ff != tll_pkg::LINE_MAX) begin
            line_in = line_ff + 1'b1;
         end
      end

      if (n == 2'd1) begin
         res[0].last_of_run = 1'b1;
      end
      if (n == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end
   end

   assign push = req_fire && (n != 2'd0);
   assign entry.two = n[1];
   assign entry.r0 = res[0];
   assign entry.r1 = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         len_ff <= '0;
         err_ff <= 1'b0;
         line_ff <= {{(tll_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      end else if (req_fire) begin
         state_ff <= state_in;
         len_ff <= len_in;
         err_ff <= err_in;
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         prefix_ff <= prefix_in;
      end
   end

   line_never_zero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter reached zero");

endmodule

// ----- rtl/tll_queue.sv -----
module tll_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tll_pkg::entry_type  push_entry,
   output logic                not_full,
   input  logic                pop,
   output logic                not_empty,
   output tll_pkg::entry_type  head
);

   tll_pkg::entry_type              slot_ff [0:tll_pkg::QUEUE_DEPTH-1];
   logic [tll_pkg::QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [tll_pkg::QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [tll_pkg::QCNT_BITS-1:0]   cnt_ff, cnt_in;

   assign not_full = cnt_ff != tll_pkg::QCNT_BITS'(tll_pkg::QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("queue push while full");

   no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

endmodule

// ----- rtl/tll_back.sv -----
module tll_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  tll_pkg::entry_type  q_head,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output tll_pkg::res_type    out_res
);

   logic              out_valid_ff, out_valid_in;
   tll_pkg::res_type  out_ff, out_in;
   logic              sec_valid_ff, sec_valid_in;
   tll_pkg::res_type  sec_ff, sec_in;
   logic              slot_free;

   assign slot_free = !out_valid_ff || out_ready;
   assign q_pop = slot_free && !sec_valid_ff && q_not_empty;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      sec_valid_in = sec_valid_ff;
      sec_in = sec_ff;
      if (slot_free) begin
         if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_in = sec_ff;
            sec_valid_in = 1'b0;
         end else if (q_not_empty) begin
            out_valid_in = 1'b1;
            out_in = q_head.r0;
            sec_valid_in = q_head.two;
            sec_in = q_head.r1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res = out_ff;

   second_follows_first: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> out_valid_ff && !out_ff.last_of_run)
      else $error("second result held without a pending first");

   second_is_last: assert property (@(posedge clock) disable iff (reset)
      sec_valid_ff |-> sec_ff.last_of_run)
      else $error("held second result not marked last");

endmodule
